// ===== rtl/sac_pkg.sv =====
package sac_pkg;
  localparam int ENTRIES_DEF   = 64;
  localparam int COUNT_MAX_DEF = 255;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHARING     = 3'd1;
  localparam logic [2:0] ST_DEL_PENDING = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
  localparam logic [2:0] ST_NOT_OPEN    = 3'd4;
  localparam logic [2:0] ST_COUNT_FULL  = 3'd5;

  // decoded request, carried from the front end to the update unit
  typedef struct packed {
    logic       is_close;
    logic [31:0] key;
    logic       wr;
    logic       ww;
    logic       wd;
    logic       sr;
    logic       sw;
    logic       sd;
    logic       doc;
  } req_t;
endpackage

// ===== rtl/sac_table.sv =====
// Entry store: valid bits in flops, key and counts in one synchronous memory.
module sac_table #(
  parameter int ENTRIES = sac_pkg::ENTRIES_DEF,
  parameter int CW      = 8,
  parameter int AW      = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [AW-1:0]     rd_addr,
  output logic [32+7*CW:0]  rd_data,
  output logic              rd_valid,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [32+7*CW:0]  wr_data,
  input  logic              wr_valid
);
  logic [32+7*CW:0] mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  // registered read, write port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid_r[rd_addr];
      if (wr_en) begin
        valid_r[wr_addr] <= wr_valid;
      end
    end
  end
endmodule

// ===== rtl/share_access_checker.sv =====
// Share-access checker. Start an item by raising start while busy is low;
// the result appears on the out_ ports for one cycle with out_strobe, and
// cannot be held off. Every item scans all ENTRIES table entries through a
// registered memory read port (one entry per cycle), then does one
// read-modify-write of the chosen entry: busy stays high from the accepting
// edge through the scan, the states S_RD and S_RDW that read back the
// chosen entry and the S_UPD state that updates it, and the result is on
// the out_ ports in the cycle after that, when busy is already low and the next item may start.
// No clearing pass is needed after reset: valid bits sit in flip-flops.
module share_access_checker #(
  parameter int ENTRIES   = sac_pkg::ENTRIES_DEF,
  parameter int COUNT_MAX = sac_pkg::COUNT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_cmd,
  input  logic [31:0] in_file_key,
  input  logic       in_want_read,
  input  logic       in_want_write,
  input  logic       in_want_delete,
  input  logic       in_want_all,
  input  logic [2:0] in_share_mode,
  input  logic       in_delete_on_close,
  output logic       out_strobe,
  output logic [2:0] out_status,
  output logic       out_unlink_now,
  output logic [7:0] out_remaining_opens
);
  import sac_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(COUNT_MAX + 1);
  localparam int DW = 33 + 7 * CW;
  localparam logic [CW-1:0] CMAX = CW'(COUNT_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  req_t        req_r;
  logic [AW:0] scan_r;      // address issued
  logic [AW-1:0] chk_r;     // address whose data is returning
  logic        chk_v_r;
  logic        hit_r, free_r;
  logic [AW-1:0] hit_idx_r, free_idx_r;

  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data, wr_data;
  logic          rd_valid, wr_en, wr_valid;
  logic [AW-1:0] wr_addr;

  sac_table #(.ENTRIES(ENTRIES), .CW(CW), .AW(AW)) u_table (
    .clk, .rst_n, .rd_addr, .rd_data, .rd_valid,
    .wr_en, .wr_addr, .wr_data, .wr_valid
  );

  assign busy = (state_r != S_IDLE);
  assign rd_addr = (state_r == S_SCAN) ? scan_r[AW-1:0] : (hit_r ? hit_idx_r : free_idx_r);

  // fields of a memory word
  logic [31:0]   m_key;
  logic [CW-1:0] m_open, m_rd, m_wrt, m_del, m_srd, m_swr, m_sdl;
  logic          m_pend;
  assign {m_key, m_open, m_rd, m_wrt, m_del, m_srd, m_swr, m_sdl, m_pend} = rd_data;

  // update of the selected entry
  logic [CW-1:0] n_open, n_rd, n_wrt, n_del, n_srd, n_swr, n_sdl;
  logic          n_pend, viol;
  logic [2:0]    st;
  logic          unl;

  function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v, input logic d);
    return (d && v != '0) ? v - CW'(1) : v;
  endfunction

  always_comb begin
    n_open = m_open; n_rd = m_rd; n_wrt = m_wrt; n_del = m_del;
    n_srd = m_srd; n_swr = m_swr; n_sdl = m_sdl; n_pend = m_pend;
    st = ST_OK; unl = 1'b0; wr_en = 1'b0; wr_valid = 1'b1;
    wr_addr = hit_r ? hit_idx_r : free_idx_r;
    if (!hit_r) begin
      n_open = '0; n_rd = '0; n_wrt = '0; n_del = '0;
      n_srd = '0; n_swr = '0; n_sdl = '0; n_pend = 1'b0;
    end
    viol = (req_r.wr && n_srd != n_open) || (req_r.ww && n_swr != n_open) ||
           (req_r.wd && n_sdl != n_open) || (!req_r.sr && n_rd != '0) ||
           (!req_r.sw && n_wrt != '0) || (!req_r.sd && n_del != '0);
    if (state_r == S_UPD) begin
      if (!req_r.is_close) begin
        if (!hit_r && !free_r) begin
          st = ST_TABLE_FULL;
        end else begin
          wr_en = 1'b1;
          if (n_pend) begin
            st = ST_DEL_PENDING;
          end else if (viol) begin
            st = ST_SHARING;
          end else if (n_open >= CMAX) begin
            st = ST_COUNT_FULL;
          end else begin
            n_open = n_open + CW'(1);
            n_rd  = n_rd  + CW'(req_r.wr);
            n_wrt = n_wrt + CW'(req_r.ww);
            n_del = n_del + CW'(req_r.wd);
            n_srd = n_srd + CW'(req_r.sr);
            n_swr = n_swr + CW'(req_r.sw);
            n_sdl = n_sdl + CW'(req_r.sd);
            n_pend = n_pend | req_r.doc;
          end
        end
      end else if (!hit_r) begin
        st = ST_NOT_OPEN;
      end else begin
        wr_en = 1'b1;
        n_open = dec_sat(n_open, 1'b1);
        n_rd  = dec_sat(n_rd, req_r.wr);
        n_wrt = dec_sat(n_wrt, req_r.ww);
        n_del = dec_sat(n_del, req_r.wd);
        n_srd = dec_sat(n_srd, req_r.sr);
        n_swr = dec_sat(n_swr, req_r.sw);
        n_sdl = dec_sat(n_sdl, req_r.sd);
        if (n_open == '0) begin
          unl = n_pend;
          n_pend = 1'b0;
          wr_valid = 1'b0;
        end
      end
    end
  end
  assign wr_data = {req_r.key, n_open, n_rd, n_wrt, n_del, n_srd, n_swr, n_sdl, n_pend};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_SCAN;
      S_SCAN: if (scan_r == (AW+1)'(ENTRIES - 1)) state_nxt = S_RD;
      S_RD:   state_nxt = S_RDW;
      S_RDW:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chk_v_r <= 1'b0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_strobe <= (state_r == S_UPD);
      chk_v_r <= (state_r == S_SCAN);
      if (state_r == S_IDLE && start) begin
        hit_r <= 1'b0;
        free_r <= 1'b0;
      end else if (chk_v_r) begin
        // lowest match and lowest free entry
        if (rd_valid && m_key == req_r.key && !hit_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= chk_r;
        end
        if (!rd_valid && !free_r) begin
          free_r <= 1'b1;
          free_idx_r <= chk_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= scan_r[AW-1:0];
    if (state_r == S_IDLE) begin
      scan_r <= '0;
      req_r <= '{is_close: in_cmd, key: in_file_key,
                 wr: in_want_read | in_want_all, ww: in_want_write | in_want_all,
                 wd: in_want_delete | in_want_all, sr: in_share_mode[0],
                 sw: in_share_mode[1], sd: in_share_mode[2], doc: in_delete_on_close};
    end else if (state_r == S_SCAN) begin
      scan_r <= scan_r + (AW+1)'(1);
    end
    if (state_r == S_UPD) begin
      out_status <= st;
      out_unlink_now <= unl;
      out_remaining_opens <= (st == ST_TABLE_FULL || st == ST_NOT_OPEN) ? 8'd0 :
                             8'(n_open);
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_UPD) else $error("strobe without update");
  a_unlink_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_unlink_now |-> out_remaining_opens == 8'd0 && out_status == ST_OK)
    else $error("unlink with opens left");
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (hit_r || free_r)) else $error("write without entry");
`endif
endmodule
